/* rtl/core/dfrc_pkg.sv */
// ----------------------------------------------------------------------------
// dfrc_pkg: shared definitions for the dual filter with reversal counter
// Widths, register indexes, reset values and the item and config structs.
// ----------------------------------------------------------------------------
package dfrc_pkg;

   // data widths
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;
   localparam int COEF_FRAC   = 14;
   localparam int NUM_TAPS    = 5;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS    = PROD_BITS + $clog2(NUM_TAPS);
   localparam int SHIFT_BITS  = ACC_BITS - COEF_FRAC;

   // window and reversal count
   localparam int WINDOW     = 50;
   localparam int WIN_BITS   = $clog2(WINDOW);
   localparam int COUNT_BITS = 6;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_A2 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE    = 3'd5;

   localparam logic signed [COEF_BITS-1:0] COEF_B0_RST = 18'sd220;
   localparam logic signed [COEF_BITS-1:0] COEF_B1_RST = 18'sd437;
   localparam logic signed [COEF_BITS-1:0] COEF_B2_RST = 18'sd220;
   localparam logic signed [COEF_BITS-1:0] COEF_A1_RST = -18'sd26993;
   localparam logic signed [COEF_BITS-1:0] COEF_A2_RST = 18'sd11484;

   // counter source select
   localparam logic MODE_AVG = 1'b0;
   localparam logic MODE_IIR = 1'b1;

   // direction of the watched output
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_RISE = 2'd1;
   localparam logic [1:0] DIR_FALL = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] avg;
      logic signed [SAMPLE_BITS-1:0] iir_in;
      logic                          win_first;
      logic                          win_last;
   } item_type;

   // filter and counter settings
   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
      logic                        mode;
   } cfg_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* rtl/core/dfrc_front.sv */
// ----------------------------------------------------------------------------
// dfrc_front: input beat acceptance and classification
// Computes the moving average and tags each beat with its window position.
// ----------------------------------------------------------------------------
module dfrc_front import dfrc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_avg_input,
   input  logic signed [SAMPLE_BITS-1:0] req_iir_input,
   input  qstat_type                     qstat,
   output logic                          push,
   output item_type                      push_item
);

   logic signed [SAMPLE_BITS-1:0] avg_prev_ff;
   logic                          first_seen_ff;
   logic [WIN_BITS-1:0]           window_pos_ff;
   logic [WIN_BITS-1:0]           window_pos_in;
   logic signed [SAMPLE_BITS:0]   avg_sum;
   logic                          win_last;

   // take a beat whenever the queue has room
   assign req_ready = !qstat.full;
   assign push      = req_valid && !qstat.full;

   // two-tap average, floor of half the sum
   assign avg_sum = (SAMPLE_BITS+1)'(req_avg_input) + (SAMPLE_BITS+1)'(avg_prev_ff);

   assign win_last      = (window_pos_ff == WIN_BITS'(WINDOW - 1));
   assign window_pos_in = win_last ? '0 : window_pos_ff + 1'b1;

   always_comb begin
      push_item.avg       = first_seen_ff ? avg_sum[SAMPLE_BITS:1] : req_avg_input;
      push_item.iir_in    = req_iir_input;
      push_item.win_first = (window_pos_ff == '0);
      push_item.win_last  = win_last;
   end

   // advance front state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff <= 1'b0;
         window_pos_ff <= '0;
      end else if (push) begin
         first_seen_ff <= 1'b1;
         window_pos_ff <= window_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         avg_prev_ff <= req_avg_input;
      end
   end

endmodule

/* rtl/core/dfrc_queue.sv */
// ----------------------------------------------------------------------------
// dfrc_queue: short FIFO between front and back
// Lets one side stall without stalling the other until it fills or empties.
// ----------------------------------------------------------------------------
module dfrc_queue import dfrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  pop_item,
   output qstat_type qstat
);

   item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // advance pointers, wrapping at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/dfrc_back.sv */
// ----------------------------------------------------------------------------
// dfrc_back: biquad filter, reversal counter and output register
// Pops one queued beat per cycle unless rsp stalls; registers the result beat.
// ----------------------------------------------------------------------------
module dfrc_back import dfrc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  qstat_type                     qstat,
   input  item_type                      pop_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_iir_out,
   output logic                          rsp_window_done,
   output logic [COUNT_BITS-1:0]         rsp_reversal_count
);

   // filter history
   logic signed [SAMPLE_BITS-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   // counter state
   logic signed [SAMPLE_BITS-1:0] last_sel_ff;
   logic [1:0]                    dir_ff;
   logic [1:0]                    dir_in;
   logic [COUNT_BITS-1:0]         rev_ff;
   logic [COUNT_BITS-1:0]         rev_in;
   logic [COUNT_BITS-1:0]         rev_upd;
   logic [COUNT_BITS-1:0]         count_out;
   // output register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] avg_out_ff, iir_out_ff;
   logic                          done_ff;
   logic [COUNT_BITS-1:0]         count_ff;

   logic signed [PROD_BITS-1:0]   p0, p1, p2, p3, p4;
   logic signed [ACC_BITS-1:0]    acc;
   logic signed [SHIFT_BITS-1:0]  acc_sh;
   logic signed [SAMPLE_BITS-1:0] iir;
   logic signed [SAMPLE_BITS-1:0] sel;
   logic                          in_range;

   // pop when the output register is free or being drained
   assign pop = !qstat.empty && (!rsp_valid_ff || rsp_ready);

   // Direct Form I products and sum
   assign p0 = PROD_BITS'(cfg.b0) * PROD_BITS'(pop_item.iir_in);
   assign p1 = PROD_BITS'(cfg.b1) * PROD_BITS'(x1_ff);
   assign p2 = PROD_BITS'(cfg.b2) * PROD_BITS'(x2_ff);
   assign p3 = PROD_BITS'(cfg.a1) * PROD_BITS'(y1_ff);
   assign p4 = PROD_BITS'(cfg.a2) * PROD_BITS'(y2_ff);
   assign acc = ACC_BITS'(p0) + ACC_BITS'(p1) + ACC_BITS'(p2)
              - ACC_BITS'(p3) - ACC_BITS'(p4);

   // truncate toward minus infinity, then saturate
   assign acc_sh   = acc[ACC_BITS-1:COEF_FRAC];
   assign in_range = (acc_sh[SHIFT_BITS-1:SAMPLE_BITS-1] == '0) ||
                     (acc_sh[SHIFT_BITS-1:SAMPLE_BITS-1] == '1);

   always_comb begin
      if (in_range) begin
         iir = acc_sh[SAMPLE_BITS-1:0];
      end else if (acc_sh[SHIFT_BITS-1]) begin
         iir = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         iir = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // reversal detection on the selected output
   assign sel = (cfg.mode == MODE_IIR) ? iir : pop_item.avg;

   always_comb begin
      dir_in  = dir_ff;
      rev_upd = rev_ff;
      if (!pop_item.win_first) begin
         if (sel > last_sel_ff) begin
            if (dir_ff == DIR_FALL && rev_ff != COUNT_MAX) begin
               rev_upd = rev_ff + 1'b1;
            end
            dir_in = DIR_RISE;
         end else if (sel < last_sel_ff) begin
            if (dir_ff == DIR_RISE && rev_ff != COUNT_MAX) begin
               rev_upd = rev_ff + 1'b1;
            end
            dir_in = DIR_FALL;
         end
      end
      // emit and clear at the window's end
      if (pop_item.win_last) begin
         count_out = rev_upd;
         rev_in    = '0;
      end else begin
         count_out = '0;
         rev_in    = rev_upd;
      end
   end

   // advance filter and counter state on each popped beat
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         last_sel_ff  <= '0;
         dir_ff       <= DIR_NONE;
         rev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pop || (rsp_valid_ff && !rsp_ready);
         if (pop) begin
            x1_ff       <= pop_item.iir_in;
            x2_ff       <= x1_ff;
            y1_ff       <= iir;
            y2_ff       <= y1_ff;
            last_sel_ff <= sel;
            dir_ff      <= dir_in;
            rev_ff      <= rev_in;
         end
      end
   end

   // load the result beat
   always_ff @(posedge clock) begin
      if (pop) begin
         avg_out_ff <= pop_item.avg;
         iir_out_ff <= iir;
         done_ff    <= pop_item.win_last;
         count_ff   <= count_out;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_avg_out        = avg_out_ff;
   assign rsp_iir_out        = iir_out_ff;
   assign rsp_window_done    = done_ff;
   assign rsp_reversal_count = count_ff;

endmodule

/* rtl/core/dual_filter_with_reversal_counter.sv */
// An accepted req beat is written to the queue, then popped into the output register.
// Throughput: 1 beat per cycle with rsp_ready high; the back unit closes biquad feedback.
// A 2-entry queue decouples the front from the back and its output register.
// Reset (synchronous, active high) clears the queue, filter history and counters,
// and loads the default coefficients with mode 0; the block is ready the next cycle.
// ----------------------------------------------------------------------------
// dual_filter_with_reversal_counter: top level
// Register file, front classifier, queue and back filter/counter unit.
// ----------------------------------------------------------------------------
module dual_filter_with_reversal_counter import dfrc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_avg_input,
   input  logic signed [SAMPLE_BITS-1:0] req_iir_input,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_iir_out,
   output logic                          rsp_window_done,
   output logic [COUNT_BITS-1:0]         rsp_reversal_count,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COEF_BITS-1:0]          csr_wdata
);

   cfg_type   cfg_ff;
   qstat_type qstat;
   logic      push;
   logic      pop;
   item_type  push_item;
   item_type  pop_item;

   // register writes; unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.b0   <= COEF_B0_RST;
         cfg_ff.b1   <= COEF_B1_RST;
         cfg_ff.b2   <= COEF_B2_RST;
         cfg_ff.a1   <= COEF_A1_RST;
         cfg_ff.a2   <= COEF_A2_RST;
         cfg_ff.mode <= MODE_AVG;
      end else if (csr_we) begin
         case (csr_index)
            REG_COEF_B0: cfg_ff.b0   <= csr_wdata;
            REG_COEF_B1: cfg_ff.b1   <= csr_wdata;
            REG_COEF_B2: cfg_ff.b2   <= csr_wdata;
            REG_COEF_A1: cfg_ff.a1   <= csr_wdata;
            REG_COEF_A2: cfg_ff.a2   <= csr_wdata;
            REG_MODE:    cfg_ff.mode <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   dfrc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_avg_input (req_avg_input),
      .req_iir_input (req_iir_input),
      .qstat         (qstat),
      .push          (push),
      .push_item     (push_item)
   );

   dfrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   dfrc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .qstat              (qstat),
      .pop_item           (pop_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_avg_out        (rsp_avg_out),
      .rsp_iir_out        (rsp_iir_out),
      .rsp_window_done    (rsp_window_done),
      .rsp_reversal_count (rsp_reversal_count)
   );

endmodule
